// ===== src/msrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrr_pkg
// Types, constants and the CRC byte update for the sensor reply receiver.
// ----------------------------------------------------------------------------
package msrr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PosW = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ADDRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FUNCTION = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [7:0] RST_ADDRESS = 8'h01;
  localparam logic [7:0] RST_FUNCTION = 8'h03;
  localparam logic [15:0] RST_TIMEOUT = 16'd500;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] BYTE_COUNT_CODE = 8'h08;

  // item kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // frame positions
  localparam logic [PosW-1:0] POS_ADDRESS = 4'd0;
  localparam logic [PosW-1:0] POS_FUNCTION = 4'd1;
  localparam logic [PosW-1:0] POS_COUNT = 4'd2;
  localparam logic [PosW-1:0] POS_HUM_HI = 4'd3;
  localparam logic [PosW-1:0] POS_HUM_LO = 4'd4;
  localparam logic [PosW-1:0] POS_TEMP_HI = 4'd5;
  localparam logic [PosW-1:0] POS_TEMP_LO = 4'd6;
  localparam logic [PosW-1:0] POS_PH_HI = 4'd9;
  localparam logic [PosW-1:0] POS_PH_LO = 4'd10;
  localparam logic [PosW-1:0] POS_CRC_LO = 4'd11;
  localparam logic [PosW-1:0] POS_CRC_HI = 4'd12;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] humidity_tenths;
    logic [15:0] temperature_tenths;
    logic [15:0] ph_tenths;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0]  expected_address;
    logic [7:0]  expected_function;
    logic [15:0] timeout_ticks;
  } cfg_regs_t;

  // CRC-16/MODBUS update by one byte, eight shift stages
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/msrr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrr_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface msrr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/modbus_sensor_reply_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_sensor_reply_receiver
// Parses Modbus RTU read replies from a byte/tick stream and emits sensor words.
//
//   channel  direction  payload
//   in_i     sink       action, rx_byte
//   out_o    source     humidity_tenths, temperature_tenths, ph_tenths
//   cfg_i    sink       index, data (always ready)
//
// One item per cycle while no result is stalled; a result passes the input
// register, then the result register, which loads it as the parser registers
// its update of position, CRC and tick count.
// Reset clears the parser to hunting, CRC to 0xFFFF and registers to defaults.
// A stalled result holds; the input register still takes an item while empty.
// ----------------------------------------------------------------------------
module modbus_sensor_reply_receiver
  import msrr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  msrr_stream_if.sink         in_i,
  msrr_stream_if.source       out_o,
  msrr_stream_if.sink         cfg_i
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      res_valid;
  out_item_t res;
  cfg_regs_t cfg_regs;
  cfg_item_t cfg_item;
  logic      cfg_ready;

  assign cfg_item = cfg_i.payload;
  assign cfg_i.ready = cfg_ready;

  msrr_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_item_i  (cfg_item),
    .wr_ready_o (cfg_ready),
    .regs_o     (cfg_regs)
  );

  // process the held item once the result register is free or draining
  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
  end

  msrr_frame_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg_regs),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

// ===== src/msrr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrr_cfg_regs
// Configuration register file: address, function code and tick timeout.
// ----------------------------------------------------------------------------
module msrr_cfg_regs
  import msrr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  input  cfg_item_t wr_item_i,
  output logic      wr_ready_o,
  output cfg_regs_t regs_o
);

  cfg_regs_t regs_q, regs_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (wr_valid_i) begin
      case (wr_item_i.index)
        REG_ADDRESS:  regs_d.expected_address = wr_item_i.data[7:0];
        REG_FUNCTION: regs_d.expected_function = wr_item_i.data[7:0];
        REG_TIMEOUT:  regs_d.timeout_ticks = wr_item_i.data[15:0];
        default:      regs_d = regs_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.expected_address <= RST_ADDRESS;
      regs_q.expected_function <= RST_FUNCTION;
      regs_q.timeout_ticks <= RST_TIMEOUT;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

// ===== src/msrr_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrr_frame_parser
// Frame position tracking, running CRC, word capture and timeout counting.
// ----------------------------------------------------------------------------
module msrr_frame_parser
  import msrr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  input  cfg_regs_t cfg_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     hum_q, hum_d;
  logic [15:0]     temp_q, temp_d;
  logic [15:0]     ph_q, ph_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic [15:0]     ticks_q, ticks_d;
  logic [7:0]      want;
  logic [15:0]     crc_next;
  logic            good;

  assign crc_next = crc_add_byte(crc_q, item_i.rx_byte);
  assign good = (pos_q == POS_CRC_HI) && (crc_q[7:0] == crc_lo_q)
              && (crc_q[15:8] == item_i.rx_byte);

  always_comb begin
    case (pos_q)
      POS_ADDRESS:  want = cfg_i.expected_address;
      POS_FUNCTION: want = cfg_i.expected_function;
      default:      want = BYTE_COUNT_CODE;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    hum_d = hum_q;
    temp_d = temp_q;
    ph_d = ph_q;
    crc_lo_d = crc_lo_q;
    ticks_d = ticks_q;
    res_valid_o = 1'b0;
    if (item_i.action == ACT_TICK) begin
      if (ticks_q >= cfg_i.timeout_ticks) begin
        pos_d = POS_ADDRESS;
        crc_d = CRC_INIT;
        ticks_d = '0;
      end else begin
        ticks_d = ticks_q + 16'd1;
      end
    end else begin
      case (pos_q) inside
        [POS_ADDRESS:POS_COUNT]: begin
          pos_d = POS_ADDRESS;
          crc_d = CRC_INIT;
          ticks_d = '0;
          if (item_i.rx_byte == want) begin
            pos_d = pos_q + 4'd1;
            crc_d = crc_next;
          end
        end
        [POS_HUM_HI:POS_PH_LO]: begin
          crc_d = crc_next;
          pos_d = pos_q + 4'd1;
          case (pos_q)
            POS_HUM_HI:  hum_d[15:8] = item_i.rx_byte;
            POS_HUM_LO:  hum_d[7:0] = item_i.rx_byte;
            POS_TEMP_HI: temp_d[15:8] = item_i.rx_byte;
            POS_TEMP_LO: temp_d[7:0] = item_i.rx_byte;
            POS_PH_HI:   ph_d[15:8] = item_i.rx_byte;
            POS_PH_LO:   ph_d[7:0] = item_i.rx_byte;
            default:     ; // reserved word: CRC only
          endcase
        end
        POS_CRC_LO: begin
          crc_lo_d = item_i.rx_byte;
          pos_d = POS_CRC_HI;
        end
        default: begin
          // frame end: restart whatever the check says
          pos_d = POS_ADDRESS;
          crc_d = CRC_INIT;
          ticks_d = '0;
          res_valid_o = good;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_ADDRESS;
      crc_q <= CRC_INIT;
      hum_q <= '0;
      temp_q <= '0;
      ph_q <= '0;
      crc_lo_q <= '0;
      ticks_q <= '0;
    end else if (advance_i) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      hum_q <= hum_d;
      temp_q <= temp_d;
      ph_q <= ph_d;
      crc_lo_q <= crc_lo_d;
      ticks_q <= ticks_d;
    end
  end

  assign res_o.humidity_tenths = hum_q;
  assign res_o.temperature_tenths = temp_q;
  assign res_o.ph_tenths = ph_q;

endmodule

// ===== src/msrr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrr_checker
// Port-level checks on the sensor reply receiver, bound to the top level.
// ----------------------------------------------------------------------------
module msrr_checker
  import msrr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i,
  input logic      cfg_ready_i
);

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  // a free or draining result side never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while result side ready");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

  // only a stalled result may block the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input blocked without a stalled result");

endmodule

bind modbus_sensor_reply_receiver msrr_checker u_msrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload),
  .cfg_ready_i (cfg_i.ready)
);
